// ----- src/lss_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types of the laplacian sharpening stream
package lss_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int FRAC_BITS  = 8;

  localparam int PIX_W   = 8;
  localparam int STR_W   = 12;
  localparam int DIM_W   = 11;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int SUM_W   = PIX_W + 2;
  localparam int DIFF_W  = PIX_W + 3;
  localparam int PROD_W  = STR_W + 1 + DIFF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int QUO_W   = ACC_W - FRAC_BITS;
  localparam int SAT_MAX = 254;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  localparam logic [STR_W-1:0] STRENGTH_RESET = 12'd256;
  localparam logic [DIM_W-1:0] WIDTH_RESET    = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET   = 11'd576;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // one column of the 3x3 neighbourhood, bottom is the newest row
  typedef struct packed {
    logic [PIX_W-1:0] bottom;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
  } column_t;

  typedef struct packed {
    logic push;
    logic emit;
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic down_ok;
    logic last;
  } stage_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] sharpened;
    logic             frame_end;
  } result_t;

endpackage

// ----- src/lss_line_mem.sv -----
`timescale 1ns / 1ps
// column-addressed line store holding the two previous rows, with write bypass
module lss_line_mem (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [lss_pkg::ADDR_W-1:0]    rd_addr,
  input  logic                          wr_en,
  input  logic [lss_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [2*lss_pkg::PIX_W-1:0]   wr_data,
  output logic [2*lss_pkg::PIX_W-1:0]   rd_data
);

  logic [2*lss_pkg::PIX_W-1:0] mem [lss_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  a_bypass: assert property (@(posedge clk)
    (rd_en && wr_en && (wr_addr == rd_addr)) |=> (rd_data === $past(wr_data)))
    else $error("line store bypass lost the word being written");

endmodule

// ----- src/lss_calc.sv -----
`timescale 1ns / 1ps
// neighbourhood window, laplacian weighting and clamp pipeline
module lss_calc (
  input  logic                         clk,
  input  logic                         rst,
  input  lss_pkg::stage_ctl_t          ctl,
  input  lss_pkg::column_t             cur,
  input  logic [lss_pkg::STR_W-1:0]    strength,
  output logic                         res_valid,
  output lss_pkg::result_t             res,
  output logic [1:0]                   pending
);

  lss_pkg::column_t            prev;
  logic [lss_pkg::PIX_W-1:0]   prev2_mid;

  logic [lss_pkg::PIX_W-1:0]   left;
  logic [lss_pkg::PIX_W-1:0]   right;
  logic [lss_pkg::PIX_W-1:0]   up;
  logic [lss_pkg::PIX_W-1:0]   down;
  logic [lss_pkg::SUM_W-1:0]   nsum;
  logic signed [lss_pkg::DIFF_W-1:0] diff_next;

  logic                               a_emit;
  logic                               a_last;
  logic [lss_pkg::PIX_W-1:0]          a_center;
  logic signed [lss_pkg::DIFF_W-1:0]  a_diff;

  logic signed [lss_pkg::PROD_W-1:0]  prod;
  logic signed [lss_pkg::ACC_W-1:0]   acc_next;

  logic                               b_emit;
  logic                               b_last;
  logic signed [lss_pkg::ACC_W-1:0]   b_acc;
  logic [lss_pkg::QUO_W-1:0]          quo;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      prev      <= cur;
      prev2_mid <= prev.mid;
    end
  end

  always_comb begin
    left  = ctl.left_ok  ? prev2_mid   : '0;
    right = ctl.right_ok ? cur.mid     : '0;
    up    = ctl.up_ok    ? prev.top    : '0;
    down  = ctl.down_ok  ? prev.bottom : '0;
    nsum  = lss_pkg::SUM_W'(left) + lss_pkg::SUM_W'(right)
          + lss_pkg::SUM_W'(up) + lss_pkg::SUM_W'(down);
    diff_next = lss_pkg::DIFF_W'({prev.mid, 2'b00}) - lss_pkg::DIFF_W'(nsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_emit <= 1'b0;
    end else begin
      a_emit <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      a_last   <= ctl.last;
      a_center <= prev.mid;
      a_diff   <= diff_next;
    end
  end

  assign prod     = $signed({1'b0, strength}) * a_diff;
  assign acc_next = lss_pkg::ACC_W'(prod)
                  + lss_pkg::ACC_W'({a_center, {lss_pkg::FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_emit <= 1'b0;
    end else begin
      b_emit <= a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_emit) begin
      b_last <= a_last;
      b_acc  <= acc_next;
    end
  end

  assign quo = b_acc[lss_pkg::ACC_W-1:lss_pkg::FRAC_BITS];

  always_comb begin
    res.frame_end = b_last;
    if (b_acc[lss_pkg::ACC_W-1]) begin
      res.sharpened = '0;
    end else if (quo > lss_pkg::QUO_W'(lss_pkg::SAT_MAX)) begin
      res.sharpened = lss_pkg::PIX_W'(lss_pkg::SAT_MAX);
    end else begin
      res.sharpened = quo[lss_pkg::PIX_W-1:0];
    end
  end

  assign res_valid = b_emit;
  assign pending   = {1'b0, a_emit} + {1'b0, b_emit};

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.sharpened <= lss_pkg::PIX_W'(lss_pkg::SAT_MAX)))
    else $error("sharpened value above clamp limit");

  a_emit_flow: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> ##1 b_emit)
    else $error("result lost inside the weighting pipeline");

endmodule

// ----- src/lss_out_fifo.sv -----
`timescale 1ns / 1ps
// output queue that decouples the receiver from the filter pipeline
module lss_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  lss_pkg::result_t                wr_data,
  input  logic                            rd_en,
  output logic                            valid,
  output lss_pkg::result_t                rd_data,
  output logic [lss_pkg::FIFO_CNT_W-1:0]  count
);

  lss_pkg::result_t                mem [lss_pkg::FIFO_DEPTH];
  logic [lss_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [lss_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic                            pop;

  assign valid   = (count != '0);
  assign pop     = valid && rd_en;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + lss_pkg::FIFO_CNT_W'(wr_en) - lss_pkg::FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !pop) |-> (count != lss_pkg::FIFO_CNT_W'(lss_pkg::FIFO_DEPTH)))
    else $error("output queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lss_pkg::FIFO_CNT_W'(lss_pkg::FIFO_DEPTH))
    else $error("output queue count out of range");

endmodule

// ----- src/laplacian_sharpen_stream.sv -----
`timescale 1ns / 1ps
// top level of the 5-point laplacian sharpening stream
// usage:
//   input stream: tuser is the item kind (pixel or drain tick), tdata the pixel.
//   pixels of a frame arrive in raster order; after the last pixel, W+1 drain
//   ticks (or surplus pixels, taken as drain) flush the tail of the frame.
//   output stream: tdata is the sharpened pixel, tlast marks the frame's last one.
//   the result for raster position p is formed once item p+W+1 is accepted and
//   is offered after the s1, a and b registers and the output queue; a drain
//   tick arriving mid-frame is dropped. throughput is one item per cycle while
//   ready is high, set by the single read-modify-write of the line store per
//   item (one read and one write port). results pass through an 8-entry output
//   queue; ready drops only when the queue plus results still in the pipeline
//   would fill it, so a stalled receiver stops input once they hold 8 results.
//   configuration is written between frames through the write port.
//   reset clears counters, queue and configuration (strength 256, 640x576);
//   the line store needs no clearing pass, every neighbour read is written first.
module laplacian_sharpen_stream (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // pixel
  input  logic                             s_axis_tuser,   // kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // sharpened
  output logic                             m_axis_tlast,   // frame_end
  input  logic                             cfg_wr_en,
  input  logic [lss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [lss_pkg::STR_W-1:0]  sharpen_strength;
  logic [lss_pkg::DIM_W-1:0]  frame_width;
  logic [lss_pkg::DIM_W-1:0]  frame_height;
  logic [lss_pkg::DIM_W-1:0]  wc;
  logic [lss_pkg::DIM_W-1:0]  hc;

  logic [lss_pkg::DIM_W-1:0]  in_column;
  logic [lss_pkg::DIM_W-1:0]  in_row;
  logic [lss_pkg::DIM_W-1:0]  out_col;
  logic [lss_pkg::DIM_W-1:0]  out_row;
  logic [lss_pkg::DIM_W-1:0]  in_column_next;
  logic [lss_pkg::DIM_W-1:0]  in_row_next;
  logic [lss_pkg::DIM_W-1:0]  out_col_next;
  logic [lss_pkg::DIM_W-1:0]  out_row_next;

  logic accept;
  logic in_frame;
  logic push;
  logic emit;
  logic col_end;
  logic out_col_end;
  logic out_row_end;
  logic last;

  lss_pkg::stage_ctl_t            s1_ctl;
  logic [lss_pkg::PIX_W-1:0]      s1_pix;
  logic [lss_pkg::ADDR_W-1:0]     s1_col;
  logic [2*lss_pkg::PIX_W-1:0]    rd_data;
  lss_pkg::column_t               cur;

  logic                           res_valid;
  lss_pkg::result_t               res;
  lss_pkg::result_t               q_data;
  logic [1:0]                     pending;
  logic [1:0]                     inflight;
  logic [lss_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [lss_pkg::FIFO_CNT_W-1:0] occupancy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sharpen_strength <= lss_pkg::STRENGTH_RESET;
      frame_width      <= lss_pkg::WIDTH_RESET;
      frame_height     <= lss_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lss_pkg::REG_STRENGTH: sharpen_strength <= cfg_data[lss_pkg::STR_W-1:0];
        lss_pkg::REG_WIDTH:    frame_width      <= cfg_data[lss_pkg::DIM_W-1:0];
        lss_pkg::REG_HEIGHT:   frame_height     <= cfg_data[lss_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      wc = lss_pkg::DIM_W'(1);
    end else if (frame_width > lss_pkg::DIM_W'(lss_pkg::MAX_WIDTH)) begin
      wc = lss_pkg::DIM_W'(lss_pkg::MAX_WIDTH);
    end else begin
      wc = frame_width;
    end
    if (frame_height == '0) begin
      hc = lss_pkg::DIM_W'(1);
    end else if (frame_height > lss_pkg::DIM_W'(lss_pkg::MAX_HEIGHT)) begin
      hc = lss_pkg::DIM_W'(lss_pkg::MAX_HEIGHT);
    end else begin
      hc = frame_height;
    end
  end

  // flow control against the output queue
  assign inflight      = pending + {1'b0, s1_ctl.emit};
  assign occupancy     = fifo_count + lss_pkg::FIFO_CNT_W'(inflight);
  assign s_axis_tready = occupancy < lss_pkg::FIFO_CNT_W'(lss_pkg::FIFO_DEPTH);

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign in_frame    = in_row < hc;
  assign push        = accept && (!in_frame || (s_axis_tuser == lss_pkg::KIND_PIXEL));
  assign emit        = push && ((in_row > lss_pkg::DIM_W'(1))
                     || ((in_row == lss_pkg::DIM_W'(1)) && (in_column != '0)));
  assign col_end     = in_column == (wc - 1'b1);
  assign out_col_end = out_col == (wc - 1'b1);
  assign out_row_end = out_row == (hc - 1'b1);
  assign last        = out_col_end && out_row_end;

  always_comb begin
    in_column_next = in_column;
    in_row_next    = in_row;
    out_col_next   = out_col;
    out_row_next   = out_row;
    if (push) begin
      if (col_end) begin
        in_column_next = '0;
        in_row_next    = in_row + 1'b1;
      end else begin
        in_column_next = in_column + 1'b1;
      end
    end
    if (emit) begin
      if (last) begin
        in_column_next = '0;
        in_row_next    = '0;
        out_col_next   = '0;
        out_row_next   = '0;
      end else if (out_col_end) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      s1_ctl    <= '0;
    end else begin
      in_column       <= in_column_next;
      in_row          <= in_row_next;
      out_col         <= out_col_next;
      out_row         <= out_row_next;
      s1_ctl.push     <= push;
      s1_ctl.emit     <= emit;
      s1_ctl.left_ok  <= out_col != '0;
      s1_ctl.right_ok <= !out_col_end;
      s1_ctl.up_ok    <= out_row != '0;
      s1_ctl.down_ok  <= !out_row_end;
      s1_ctl.last     <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_pix <= in_frame ? s_axis_tdata : '0;
      s1_col <= in_column[lss_pkg::ADDR_W-1:0];
    end
  end

  lss_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (push),
    .rd_addr (in_column[lss_pkg::ADDR_W-1:0]),
    .wr_en   (s1_ctl.push),
    .wr_addr (s1_col),
    .wr_data ({s1_pix, rd_data[2*lss_pkg::PIX_W-1:lss_pkg::PIX_W]}),
    .rd_data (rd_data)
  );

  assign cur.bottom = s1_pix;
  assign cur.mid    = rd_data[2*lss_pkg::PIX_W-1:lss_pkg::PIX_W];
  assign cur.top    = rd_data[lss_pkg::PIX_W-1:0];

  lss_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (s1_ctl),
    .cur       (cur),
    .strength  (sharpen_strength),
    .res_valid (res_valid),
    .res       (res),
    .pending   (pending)
  );

  lss_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (m_axis_tready),
    .valid   (m_axis_tvalid),
    .rd_data (q_data),
    .count   (fifo_count)
  );

  assign m_axis_tdata = q_data.sharpened;
  assign m_axis_tlast = q_data.frame_end;

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> ((in_column == '0) && (in_row == '0)
                        && (out_col == '0) && (out_row == '0)))
    else $error("counters not cleared after the last result of a frame");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    ((fifo_count == '0) && (inflight == '0)) |-> s_axis_tready)
    else $error("input stalled with nothing pending");

  a_early_drain: assert property (@(posedge clk) disable iff (rst)
    (accept && in_frame && (s_axis_tuser == lss_pkg::KIND_DRAIN))
      |=> ($stable(in_row) && $stable(in_column)))
    else $error("drain tick inside a frame moved the input position");

endmodule
